@@ hw/rtl/flla_pkg.sv @@
// ============================================================================
// flla_pkg: shared types and constants for the least-loaded flow owner block
// Field widths, counter widths, sequencer states and counter control bundle.
// ============================================================================
`default_nettype none

package flla_pkg;

    // Field and register widths fixed by the item format.
    localparam int KEY_W      = 16;
    localparam int OWNER_W    = 3;
    localparam int CFG_W      = 4;
    localparam int HANDLED_W  = 48;
    localparam int ASSIGNED_W = 17;

    // Worker count after reset.
    localparam logic [CFG_W-1:0] WORKER_COUNT_RESET = 4'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_LOOK,
        ST_SCAN,
        ST_ASSIGN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    // Increment requests toward the worker counter bank.
    typedef struct packed {
        logic inc_handled;
        logic inc_assigned;
    } cnt_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/flla_owner_ram.sv @@
// ============================================================================
// flla_owner_ram: owner table storage
// Single-port memory, one access per cycle, registered read data.
// ============================================================================
`default_nettype none

module flla_owner_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 4
) (
    input  wire logic                     clk,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic                     we,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/flla_load_ctr.sv @@
// ============================================================================
// flla_load_ctr: per-worker load counters
// Handled-event and assigned-key counters with one shared read and
// increment port; both counters saturate at their maximum.
// ============================================================================
`default_nettype none

module flla_load_ctr #(
    parameter int MAX_WORKERS = 8,
    parameter int WID_W       = 3
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [WID_W-1:0]                sel,
    input  wire flla_pkg::cnt_ctrl_t             ctrl,
    output logic      [flla_pkg::HANDLED_W-1:0]  rd_handled,
    output logic      [flla_pkg::ASSIGNED_W-1:0] rd_assigned
);

    import flla_pkg::*;

    logic [HANDLED_W-1:0]  handled_reg   [MAX_WORKERS];
    logic [HANDLED_W-1:0]  handled_next  [MAX_WORKERS];
    logic [ASSIGNED_W-1:0] assigned_reg  [MAX_WORKERS];
    logic [ASSIGNED_W-1:0] assigned_next [MAX_WORKERS];

    // Read the selected worker.
    assign rd_handled  = handled_reg[sel];
    assign rd_assigned = assigned_reg[sel];

    // Saturating increments on the selected worker.
    always_comb
    begin
        handled_next  = handled_reg;
        assigned_next = assigned_reg;
        if (ctrl.inc_handled && (handled_reg[sel] != '1))
        begin
            handled_next[sel] = handled_reg[sel] + 1'b1;
        end
        if (ctrl.inc_assigned && (assigned_reg[sel] != '1))
        begin
            assigned_next[sel] = assigned_reg[sel] + 1'b1;
        end
    end

    // Counter registers, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_WORKERS; i++)
            begin
                handled_reg[i]  <= '0;
                assigned_reg[i] <= '0;
            end
        end
        else
        begin
            handled_reg  <= handled_next;
            assigned_reg <= assigned_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/flla_best_track.sv @@
// ============================================================================
// flla_best_track: least-loaded worker tracker
// Holds the best candidate so far and compares one new worker per cycle,
// by handled events first and assigned keys second; ties keep the earlier.
// ============================================================================
`default_nettype none

module flla_best_track #(
    parameter int WID_W = 3
) (
    input  wire logic                            clk,
    input  wire logic                            load,
    input  wire logic                            step,
    input  wire logic [WID_W-1:0]                cand_idx,
    input  wire logic [flla_pkg::HANDLED_W-1:0]  cand_handled,
    input  wire logic [flla_pkg::ASSIGNED_W-1:0] cand_assigned,
    output logic      [WID_W-1:0]                best_idx
);

    import flla_pkg::*;

    logic [HANDLED_W-1:0]  best_handled_reg;
    logic [ASSIGNED_W-1:0] best_assigned_reg;
    logic [WID_W-1:0]      best_idx_reg;
    logic                  cand_less;

    // Strictly lower load wins.
    assign cand_less = (cand_handled < best_handled_reg) ||
                       ((cand_handled == best_handled_reg) &&
                        (cand_assigned < best_assigned_reg));

    // Best candidate registers.
    always_ff @(posedge clk)
    begin
        if (load || (step && cand_less))
        begin
            best_handled_reg  <= cand_handled;
            best_assigned_reg <= cand_assigned;
            best_idx_reg      <= cand_idx;
        end
    end

    assign best_idx = best_idx_reg;

endmodule

`default_nettype wire

@@ hw/rtl/flow_owner_least_loaded_assign_core.sv @@
// ============================================================================
// flow_owner_least_loaded_assign_core: key to worker dispatch by least load
// Returns the owning worker of each key, assigning new keys to the least
// loaded eligible worker.
// ============================================================================
`default_nettype none

// After reset the block sweeps the owner table once to mark every key
// unassigned, one entry per cycle, and takes no item until the sweep ends.
// Then it works on one item at a time. The key is first reduced modulo
// KEY_COUNT with 17 - log2(KEY_COUNT) compare-subtract steps (one step with
// the default), then the single-port owner table is read. A known key keeps
// its owner; a new key walks the eligible workers through the single load
// comparator, one a cycle, and then writes its owner into the table.
// Worker count writes are always taken and belong between items: a write
// while an item is in flight can reach that item's worker scan. The result
// register lets the next item in while the last result waits.

module flow_owner_least_loaded_assign_core #(
    parameter int MAX_WORKERS = 8,
    parameter int KEY_COUNT   = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Worker count register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,    // [3:0] worker_count
    // Event keys in.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,     // [15:0] locate
    // Owner results out.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata      // [2:0] owner, [3] newly_assigned
);

    import flla_pkg::*;

    localparam int IDX_W         = $clog2(KEY_COUNT);
    localparam int WID_W         = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int NW            = $clog2(MAX_WORKERS + 1);
    localparam int REDUCE_STEPS  = KEY_W + 1 - IDX_W;
    localparam int STEP_W        = $clog2(REDUCE_STEPS + 1);
    localparam logic [KEY_W:0] DV_INIT =
        (KEY_W + 1)'(KEY_COUNT * (2 ** (REDUCE_STEPS - 1)));

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_reg;
    logic [NW-1:0]     elig;
    logic [CFG_W:0]    cfg_ext;

    logic [KEY_W-1:0]  rem_reg, rem_next;
    logic [KEY_W:0]    dv_reg, dv_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [NW-1:0]     scan_reg, scan_next;
    logic [WID_W-1:0]  who_reg, who_next;
    logic              fresh_reg, fresh_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [OWNER_W-1:0] m_owner_reg, m_owner_next;
    logic              m_fresh_reg, m_fresh_next;

    logic [IDX_W-1:0]  ram_addr;
    logic              ram_we;
    logic [WID_W:0]    ram_wdata;
    logic [WID_W:0]    ram_rdata;

    logic [WID_W-1:0]      sel;
    cnt_ctrl_t             cnt_ctrl;
    logic [HANDLED_W-1:0]  rd_handled;
    logic [ASSIGNED_W-1:0] rd_assigned;

    logic              bt_load;
    logic              bt_step;
    logic [WID_W-1:0]  best_idx;
    logic [3:0]        who_ext;

    // Configuration register; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= WORKER_COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            cfg_reg <= cfg_data;
        end
    end

    // Eligible worker count: zero counts as one, large values clamp.
    assign cfg_ext = {1'b0, cfg_reg};

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            elig = NW'(1);
        end
        else if (cfg_ext > (CFG_W + 1)'(MAX_WORKERS))
        begin
            elig = NW'(MAX_WORKERS);
        end
        else
        begin
            elig = NW'(cfg_ext);
        end
    end

    // Owner table: valid bit above the owner index.
    flla_owner_ram #(
        .DEPTH (KEY_COUNT),
        .WIDTH (WID_W + 1)
    ) u_owner_ram (
        .clk   (clk),
        .addr  (ram_addr),
        .we    (ram_we),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Worker counters.
    flla_load_ctr #(
        .MAX_WORKERS (MAX_WORKERS),
        .WID_W       (WID_W)
    ) u_load_ctr (
        .clk         (clk),
        .rst_n       (rst_n),
        .sel         (sel),
        .ctrl        (cnt_ctrl),
        .rd_handled  (rd_handled),
        .rd_assigned (rd_assigned)
    );

    // Shared load comparator.
    flla_best_track #(
        .WID_W (WID_W)
    ) u_best_track (
        .clk           (clk),
        .load          (bt_load),
        .step          (bt_step),
        .cand_idx      (sel),
        .cand_handled  (rd_handled),
        .cand_assigned (rd_assigned),
        .best_idx      (best_idx)
    );

    // Sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dv_reg      <= dv_next;
        step_reg    <= step_next;
        scan_reg    <= scan_next;
        who_reg     <= who_next;
        fresh_reg   <= fresh_next;
        m_owner_reg <= m_owner_next;
        m_fresh_reg <= m_fresh_next;
    end

    assign who_ext = 4'(who_reg);

    // Next state and datapath control.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        rem_next      = rem_reg;
        dv_next       = dv_reg;
        step_next     = step_reg;
        scan_next     = scan_reg;
        who_next      = who_reg;
        fresh_next    = fresh_reg;
        m_owner_next  = m_owner_reg;
        m_fresh_next  = m_fresh_reg;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        s_tready      = 1'b0;
        ram_addr      = rem_reg[IDX_W-1:0];
        ram_we        = 1'b0;
        ram_wdata     = {1'b1, best_idx};
        sel           = '0;
        cnt_ctrl      = '0;
        bt_load       = 1'b0;
        bt_step       = 1'b0;

        case (state_reg)
            // Mark every key unassigned after reset.
            ST_CLEAR:
            begin
                ram_addr  = clr_reg;
                ram_we    = 1'b1;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(KEY_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take a new item.
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    rem_next   = s_tdata;
                    dv_next    = DV_INIT;
                    step_next  = STEP_W'(REDUCE_STEPS - 1);
                    state_next = ST_REDUCE;
                end
            end

            // One restoring step of key modulo table size.
            ST_REDUCE:
            begin
                if ({1'b0, rem_reg} >= dv_reg)
                begin
                    rem_next = KEY_W'({1'b0, rem_reg} - dv_reg);
                end
                dv_next   = dv_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_READ;
                end
            end

            // Table read issued; data arrives next cycle.
            ST_READ:
            begin
                state_next = ST_LOOK;
            end

            // Known key keeps its owner, a new key starts the scan at worker 0.
            ST_LOOK:
            begin
                if (ram_rdata[WID_W])
                begin
                    who_next   = ram_rdata[WID_W-1:0];
                    fresh_next = 1'b0;
                    state_next = ST_UPDATE;
                end
                else
                begin
                    bt_load    = 1'b1;
                    scan_next  = NW'(1);
                    state_next = ST_SCAN;
                end
            end

            // Compare one more eligible worker per cycle.
            ST_SCAN:
            begin
                sel = scan_reg[WID_W-1:0];
                if (scan_reg < elig)
                begin
                    bt_step   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_ASSIGN;
                end
            end

            // Record the new owner and count the assigned key.
            ST_ASSIGN:
            begin
                sel                   = best_idx;
                ram_we                = 1'b1;
                cnt_ctrl.inc_assigned = 1'b1;
                who_next              = best_idx;
                fresh_next            = 1'b1;
                state_next            = ST_UPDATE;
            end

            // Count the handled event for its owner.
            ST_UPDATE:
            begin
                sel                  = who_reg;
                cnt_ctrl.inc_handled = 1'b1;
                state_next           = ST_OUT;
            end

            // Hand the result to the output register once it is free.
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_owner_next  = who_ext[OWNER_W-1:0];
                    m_fresh_next  = fresh_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result port.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, m_fresh_reg, m_owner_reg};

    // A new owner is always one of the eligible workers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ASSIGN) |-> (NW'(best_idx) < elig))
    else $error("new owner outside the eligible workers");

    // A result appears only when the sequencer hands it over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !$past(m_tvalid)) |-> $past(state_reg == ST_OUT))
    else $error("result raised outside the output step");

    // An accepted item always starts the key reduction.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_REDUCE))
    else $error("accepted item did not start processing");

    // No item is taken during the table clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
    else $error("item taken while the owner table is being cleared");

endmodule

`default_nettype wire

@@ verif/flow_owner_least_loaded_assign_core_tb.sv @@
// ============================================================================
// flow_owner_least_loaded_assign_core_tb: self-checking bench for key dispatch
// Streams event keys into the block and predicts each owner and new-key flag
// from a private model of the owner table and the per-worker load counters.
// Random gaps and output stalls are applied, and the worker count is changed
// between phases while the block is idle.
// ============================================================================
`default_nettype none

module flow_owner_least_loaded_assign_core_tb;

    import flla_pkg::*;

    localparam int WORKERS       = 8;
    localparam int KEYS          = 65536;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 64;

    // Expected result of one event.
    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic               fresh;
    } owner_result_t;

    // Tracks key ownership and worker load, and holds the owners still owed.
    class owner_tracker;
        bit                  known [KEYS];
        bit [OWNER_W-1:0]    owner_of [KEYS];
        bit [HANDLED_W-1:0]  handled [WORKERS];
        bit [ASSIGNED_W-1:0] assigned [WORKERS];
        bit [CFG_W-1:0]      worker_count;
        owner_result_t       pending_owners [$];
        int                  failures;

        function new();
            worker_count = WORKER_COUNT_RESET;
            failures     = 0;
        endfunction

        function void write_count(logic [CFG_W-1:0] value);
            worker_count = value;
        endfunction

        // A count of zero still leaves worker 0; large counts clip at the bank size.
        function int eligible();
            int n;
            n = worker_count;
            if (n == 0)
                n = 1;
            if (n > WORKERS)
                n = WORKERS;
            return n;
        endfunction

        // Note one accepted key and queue the owner it must come back with.
        function void note_event(logic [KEY_W-1:0] locate);
            int            idx;
            int            best;
            int            n;
            owner_result_t res;
            idx = int'(locate) % KEYS;
            if (known[idx])
            begin
                res.owner = owner_of[idx];
                res.fresh = 1'b0;
            end
            else
            begin
                // Least events handled wins, then fewest keys, then lowest index.
                n    = eligible();
                best = 0;
                for (int i = 1; i < n; i++)
                begin
                    if (handled[i] < handled[best] ||
                        (handled[i] == handled[best] && assigned[i] < assigned[best]))
                        best = i;
                end
                known[idx]    = 1'b1;
                owner_of[idx] = OWNER_W'(best);
                if (assigned[best] != '1)
                    assigned[best]++;
                res.owner = OWNER_W'(best);
                res.fresh = 1'b1;
            end
            if (handled[res.owner] != '1)
                handled[res.owner]++;
            pending_owners.push_back(res);
        endfunction

        // Compare one result item with the oldest owed owner.
        function void check_result(logic [7:0] data);
            owner_result_t want;
            if (pending_owners.size() == 0)
            begin
                $display("%0t: result with nothing owed: owner=%0d newly_assigned=%0b",
                         $time, data[OWNER_W-1:0], data[OWNER_W]);
                failures++;
                return;
            end
            want = pending_owners.pop_front();
            if (data[OWNER_W-1:0] !== want.owner)
            begin
                $display("%0t: owner mismatch: expected %0d, actual %0d",
                         $time, want.owner, data[OWNER_W-1:0]);
                failures++;
            end
            if (data[OWNER_W] !== want.fresh)
            begin
                $display("%0t: newly_assigned mismatch: expected %0b, actual %0b",
                         $time, want.fresh, data[OWNER_W]);
                failures++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic             s_tvalid;
    logic             s_tready;
    logic [KEY_W-1:0] s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [7:0]       m_tdata;

    owner_tracker     book = new();
    logic [KEY_W-1:0] sent_keys [$];
    int               idle_pct;
    bit               calm;
    int               cycles;

    // Worker counts and idle rates of the random phases.
    int phase_counts [PHASES] = '{8, 3, 1, 9, 6, 2, 0, 5, 12, 7, 4};
    int phase_idle   [PHASES] = '{25, 0, 50, 15, 60, 25, 0, 40, 20, 30, 0};

    flow_owner_least_loaded_assign_core #(
        .MAX_WORKERS (WORKERS),
        .KEY_COUNT   (KEYS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Handshake monitor: every accepted item is seen at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                book.write_count(cfg_data);
            if (s_tvalid && s_tready)
                book.note_event(s_tdata);
            if (m_tvalid && m_tready)
                book.check_result(m_tdata);
        end
    end

    // Run limit, which also covers the table clearing pass after reset.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: ready with stall bursts of random length.
    initial
    begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall == 0 && !calm && $urandom_range(0, 99) < idle_pct)
                stall = $urandom_range(1, 7);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Present one key and hold it until taken, then maybe leave a gap.
    task automatic send_key(input logic [KEY_W-1:0] key);
        int gap;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_keys.push_back(key);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 7);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop sending and wait until every owed result has come back.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (book.pending_owners.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Worker count writes happen only with the block idle.
    task automatic write_worker_count(input logic [CFG_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // About half repeat a known key; the rest are fresh or at the key extremes.
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && sent_keys.size() > 0)
            return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
        if (r < 55)
            return r[0] ? 16'hFFFF : 16'h0000;
        return KEY_W'($urandom_range(0, 65535));
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        idle_pct  = 0;
        calm      = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset worker count: key extremes, alternating bits and repeats.
        send_key(16'h0000);
        send_key(16'hFFFF);
        send_key(16'h0001);
        send_key(16'h8000);
        send_key(16'h5555);
        send_key(16'hAAAA);
        send_key(16'h0000);
        send_key(16'hFFFF);
        send_key(16'h00FF);

        // A count of zero sends new keys to worker 0; known keys keep their
        // owner even past the new count.
        write_worker_count(4'd0);
        send_key(16'h1111);
        send_key(16'h2222);
        send_key(16'h8000);
        send_key(16'h3333);

        // An oversized count clips to the full bank.
        write_worker_count(4'd15);
        for (int i = 0; i < 9; i++)
            send_key(16'h0100 + KEY_W'(i));

        // A single eligible worker.
        write_worker_count(4'd1);
        send_key(16'h4444);
        send_key(16'hAAAA);

        // Random phases over a spread of worker counts.
        for (int p = 0; p < PHASES; p++)
        begin
            write_worker_count(CFG_W'(phase_counts[p]));
            idle_pct = phase_idle[p];
            calm     = (p == PHASES - 1);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_key(pick_key());
                // Hold off once mid-phase until every result is back.
                if (p == 4 && k == PHASE_ITEMS / 2)
                    drain();
            end
        end

        drain();
        if (book.failures == 0 && book.pending_owners.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
